// ===== hw/rtl/tkd_pkg.sv =====
// tkd_pkg: types, codes and constants shared by the terminal key sequence decoder
// no dependencies; imported by every module of the decoder

package tkd_pkg;

  localparam int MAX_PARAM_BYTES = 16;
  localparam int PLEN_W          = $clog2(MAX_PARAM_BYTES + 2);
  localparam int HEAD_DEPTH      = 3;
  localparam int HEAD_IDX_W      = $clog2(HEAD_DEPTH);
  localparam int WIN_DEPTH       = 5;
  localparam int FILL_W          = $clog2(WIN_DEPTH + 1);
  localparam int WAIT_W          = 16;
  localparam int CFG_W           = 16;
  localparam int CFG_IDX_W       = 1;
  localparam int CP_W            = 21;

  localparam logic [WAIT_W-1:0] ESC_WAIT_RST = 16'd30;
  localparam logic [WAIT_W-1:0] SEQ_WAIT_RST = 16'd50;
  localparam logic [WAIT_W-1:0] WAIT_MAX     = 16'hffff;

  // terminator of a bracketed paste, first byte in the top bits
  localparam logic [47:0] PASTE_TERM = 48'h1b5b3230317e;

  localparam logic [7:0] BYTE_ESC    = 8'h1b;
  localparam logic [7:0] BYTE_CR     = 8'h0d;
  localparam logic [7:0] BYTE_LF     = 8'h0a;
  localparam logic [7:0] BYTE_DEL    = 8'h7f;
  localparam logic [7:0] BYTE_BS     = 8'h08;
  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] BYTE_CTRL_C = 8'h03;
  localparam logic [7:0] BYTE_CTRL_D = 8'h04;
  localparam logic [7:0] BYTE_CTRL_O = 8'h0f;
  localparam logic [7:0] BYTE_CTRL_E = 8'h05;
  localparam logic [7:0] BYTE_LBRACK = 8'h5b;
  localparam logic [7:0] BYTE_SS3    = 8'h4f;
  localparam logic [7:0] BYTE_Z      = 8'h5a;
  localparam logic [7:0] BYTE_TILDE  = 8'h7e;
  localparam logic [7:0] BYTE_ZERO   = 8'h30;
  localparam logic [7:0] BYTE_ONE    = 8'h31;
  localparam logic [7:0] BYTE_TWO    = 8'h32;
  localparam logic [7:0] BYTE_FOUR   = 8'h34;
  localparam logic [7:0] BYTE_SEVEN  = 8'h37;
  localparam logic [7:0] BYTE_EIGHT  = 8'h38;
  localparam logic [7:0] FINAL_LO    = 8'h40;
  localparam logic [7:0] FINAL_HI    = 8'h7e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ESC_WAIT = 1'b0,
    CFG_SEQ_WAIT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_ESC   = 3'd1,
    MODE_CSI   = 3'd2,
    MODE_SS3   = 3'd3,
    MODE_UTF8  = 3'd4,
    MODE_PASTE = 3'd5
  } parse_mode_e;

  typedef enum logic [4:0] {
    KEY_CHAR       = 5'd0,
    KEY_ENTER      = 5'd1,
    KEY_NEWLINE    = 5'd2,
    KEY_BACKSPACE  = 5'd3,
    KEY_TAB        = 5'd4,
    KEY_ESC        = 5'd5,
    KEY_UP         = 5'd6,
    KEY_DOWN       = 5'd7,
    KEY_RIGHT      = 5'd8,
    KEY_LEFT       = 5'd9,
    KEY_HOME       = 5'd10,
    KEY_END        = 5'd11,
    KEY_SHIFT_TAB  = 5'd12,
    KEY_CTRL_C     = 5'd13,
    KEY_CTRL_D     = 5'd14,
    KEY_CTRL_O     = 5'd15,
    KEY_CTRL_E     = 5'd16,
    KEY_PASTE_BYTE = 5'd17,
    KEY_PASTE_END  = 5'd18
  } key_kind_e;

  typedef struct packed {
    logic       start;
    logic       push;
    logic [7:0] data;
  } paste_ctl_t;

  typedef struct packed {
    logic       full;
    logic       term_hit;
    logic [7:0] oldest;
  } paste_res_t;

  typedef struct packed {
    logic            vld;
    key_kind_e       kind;
    logic [CP_W-1:0] cp;
  } key_res_t;

endpackage

// ===== hw/rtl/tkd_in_if.sv =====
// tkd_in_if: input channel of the key decoder, valid/ready with command and byte
// no dependencies

interface tkd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink (input valid, command, data_byte, output ready);
endinterface

// ===== hw/rtl/tkd_out_if.sv =====
// tkd_out_if: result channel of the key decoder, valid/ready with key kind and code point
// no dependencies

interface tkd_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  key_kind;
  logic [20:0] code_point;

  modport source (output valid, key_kind, code_point, input ready);
  modport sink (input valid, key_kind, code_point, output ready);
endinterface

// ===== hw/rtl/tkd_paste_win.sv =====
// tkd_paste_win: five-byte window that delays pasted bytes and spots the paste terminator
// depends on tkd_pkg

module tkd_paste_win import tkd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  paste_ctl_t ctl_i,
  output paste_res_t res_o
);

  logic [FILL_W-1:0] fill_q, fill_d;
  logic [7:0]        win_q [WIN_DEPTH];
  logic              full;
  logic              term_hit;

  assign full     = (fill_q == FILL_W'(WIN_DEPTH));
  assign term_hit = full && ({win_q[0], win_q[1], win_q[2], win_q[3], win_q[4], ctl_i.data}
                             == PASTE_TERM);

  assign res_o.full     = full;
  assign res_o.term_hit = term_hit;
  assign res_o.oldest   = win_q[0];

  always_comb begin
    fill_d = fill_q;
    if (ctl_i.start) begin
      fill_d = '0;
    end else if (ctl_i.push) begin
      if (!full) begin
        fill_d = fill_q + FILL_W'(1);
      end else if (term_hit) begin
        fill_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push && !ctl_i.start) begin
      if (!full) begin
        win_q[fill_q] <= ctl_i.data;
      end else if (!term_hit) begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[WIN_DEPTH-1] <= ctl_i.data;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WIN_DEPTH))
    else $error("paste window fill beyond depth");

  a_term_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push && term_hit |=> fill_q == '0)
    else $error("paste window not emptied on terminator");
`endif

endmodule

// ===== hw/rtl/tkd_decode.sv =====
// tkd_decode: parser state and next-state logic for one item per step
// depends on tkd_pkg and tkd_paste_win

module tkd_decode import tkd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              cmd_i,
  input  logic [7:0]        byte_i,
  input  logic [CFG_W-1:0]  esc_wait_i,
  input  logic [CFG_W-1:0]  seq_wait_i,
  output key_res_t          res_o
);

  typedef struct packed {
    logic      hit;
    key_kind_e kind;
  } arrow_t;

  function automatic arrow_t arrow_kind(input logic [7:0] b);
    arrow_t r;
    r.hit  = 1'b1;
    r.kind = KEY_UP;
    case (b)
      8'h41:   r.kind = KEY_UP;
      8'h42:   r.kind = KEY_DOWN;
      8'h43:   r.kind = KEY_RIGHT;
      8'h44:   r.kind = KEY_LEFT;
      8'h48:   r.kind = KEY_HOME;
      8'h46:   r.kind = KEY_END;
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  parse_mode_e       mode_q, mode_d;
  logic [WAIT_W-1:0] wait_q, wait_d;
  logic [CP_W-1:0]   accum_q, accum_d;
  logic [1:0]        left_q, left_d;
  logic [PLEN_W-1:0] plen_q, plen_d;
  logic [7:0]        head_q [HEAD_DEPTH];
  logic              head_we;

  logic [WAIT_W-1:0] wait_inc;
  logic [WAIT_W-1:0] limit;
  logic [PLEN_W-1:0] plen_inc;
  logic [1:0]        left_dec;
  logic              in_seq;
  arrow_t            arrow;
  paste_ctl_t        pctl;
  paste_res_t        pres;
  key_res_t          res;

  tkd_paste_win u_paste_win (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (pctl),
    .res_o  (pres)
  );

  assign wait_inc = (wait_q != WAIT_MAX) ? wait_q + WAIT_W'(1) : wait_q;
  assign limit    = (mode_q == MODE_ESC) ? esc_wait_i : seq_wait_i;
  assign plen_inc = plen_q + PLEN_W'(1);
  assign left_dec = (left_q != 2'd0) ? left_q - 2'd1 : left_q;
  assign in_seq   = (mode_q == MODE_ESC) || (mode_q == MODE_CSI) ||
                    (mode_q == MODE_SS3) || (mode_q == MODE_UTF8);
  assign arrow    = arrow_kind(byte_i);
  assign res_o    = res;

  always_comb begin
    mode_d    = mode_q;
    wait_d    = wait_q;
    accum_d   = accum_q;
    left_d    = left_q;
    plen_d    = plen_q;
    head_we   = 1'b0;
    pctl      = '{start: 1'b0, push: 1'b0, data: byte_i};
    res       = '{vld: 1'b0, kind: KEY_CHAR, cp: '0};
    if (step_i) begin
      if (cmd_i == CMD_TICK) begin
        if (in_seq) begin
          if (wait_inc < limit) begin
            wait_d = wait_inc;
          end else begin
            wait_d = '0;
            mode_d = MODE_IDLE;
            if (mode_q == MODE_ESC) begin
              res.vld  = 1'b1;
              res.kind = KEY_ESC;
            end else begin
              left_d = 2'd0;
            end
          end
        end
      end else begin
        case (mode_q)
          MODE_ESC: begin
            if (byte_i == BYTE_LBRACK) begin
              mode_d = MODE_CSI;
              plen_d = '0;
              wait_d = '0;
            end else if (byte_i == BYTE_SS3) begin
              mode_d = MODE_SS3;
              wait_d = '0;
            end else begin
              mode_d = MODE_IDLE;
              if (byte_i == BYTE_CR || byte_i == BYTE_LF) begin
                res.vld  = 1'b1;
                res.kind = KEY_NEWLINE;
              end
            end
          end
          MODE_CSI: begin
            wait_d = '0;
            if (byte_i >= FINAL_LO && byte_i <= FINAL_HI) begin
              mode_d = MODE_IDLE;
              if (arrow.hit) begin
                res.vld  = 1'b1;
                res.kind = arrow.kind;
              end else if (byte_i == BYTE_Z) begin
                res.vld  = 1'b1;
                res.kind = KEY_SHIFT_TAB;
              end else if (byte_i == BYTE_TILDE) begin
                if (plen_q == PLEN_W'(3) && head_q[0] == BYTE_TWO &&
                    head_q[1] == BYTE_ZERO && head_q[2] == BYTE_ZERO) begin
                  mode_d     = MODE_PASTE;
                  pctl.start = 1'b1;
                end else if (plen_q == PLEN_W'(1)) begin
                  if (head_q[0] == BYTE_ONE || head_q[0] == BYTE_SEVEN) begin
                    res.vld  = 1'b1;
                    res.kind = KEY_HOME;
                  end else if (head_q[0] == BYTE_FOUR || head_q[0] == BYTE_EIGHT) begin
                    res.vld  = 1'b1;
                    res.kind = KEY_END;
                  end
                end
              end
            end else begin
              head_we = (plen_q < PLEN_W'(HEAD_DEPTH));
              plen_d  = plen_inc;
              if (plen_inc > PLEN_W'(MAX_PARAM_BYTES)) begin
                plen_d = '0;
                mode_d = MODE_IDLE;
              end
            end
          end
          MODE_SS3: begin
            mode_d = MODE_IDLE;
            if (arrow.hit) begin
              res.vld  = 1'b1;
              res.kind = arrow.kind;
            end
          end
          MODE_UTF8: begin
            wait_d = '0;
            if (byte_i[7:6] != 2'b10) begin
              mode_d = MODE_IDLE;
              left_d = 2'd0;
            end else begin
              accum_d = {accum_q[CP_W-7:0], byte_i[5:0]};
              left_d  = left_dec;
              if (left_dec == 2'd0) begin
                mode_d   = MODE_IDLE;
                res.vld  = 1'b1;
                res.kind = KEY_CHAR;
                res.cp   = {accum_q[CP_W-7:0], byte_i[5:0]};
              end
            end
          end
          MODE_PASTE: begin
            pctl.push = 1'b1;
            if (pres.term_hit) begin
              mode_d   = MODE_IDLE;
              res.vld  = 1'b1;
              res.kind = KEY_PASTE_END;
            end else if (pres.full) begin
              res.vld  = 1'b1;
              res.kind = KEY_PASTE_BYTE;
              res.cp   = CP_W'(pres.oldest);
            end
          end
          default: begin
            mode_d = MODE_IDLE;
            case (byte_i)
              BYTE_ESC: begin
                mode_d = MODE_ESC;
                wait_d = '0;
              end
              BYTE_CR, BYTE_LF: begin
                res.vld  = 1'b1;
                res.kind = KEY_ENTER;
              end
              BYTE_DEL, BYTE_BS: begin
                res.vld  = 1'b1;
                res.kind = KEY_BACKSPACE;
              end
              BYTE_TAB: begin
                res.vld  = 1'b1;
                res.kind = KEY_TAB;
              end
              BYTE_CTRL_C: begin
                res.vld  = 1'b1;
                res.kind = KEY_CTRL_C;
              end
              BYTE_CTRL_D: begin
                res.vld  = 1'b1;
                res.kind = KEY_CTRL_D;
              end
              BYTE_CTRL_O: begin
                res.vld  = 1'b1;
                res.kind = KEY_CTRL_O;
              end
              BYTE_CTRL_E: begin
                res.vld  = 1'b1;
                res.kind = KEY_CTRL_E;
              end
              default: begin
                if (byte_i < 8'h20) begin
                  res.vld = 1'b0;
                end else if (byte_i < 8'h80) begin
                  res.vld  = 1'b1;
                  res.kind = KEY_CHAR;
                  res.cp   = CP_W'(byte_i);
                end else if (byte_i[7:5] == 3'b110) begin
                  accum_d = CP_W'(byte_i[4:0]);
                  left_d  = 2'd1;
                  mode_d  = MODE_UTF8;
                  wait_d  = '0;
                end else if (byte_i[7:4] == 4'b1110) begin
                  accum_d = CP_W'(byte_i[3:0]);
                  left_d  = 2'd2;
                  mode_d  = MODE_UTF8;
                  wait_d  = '0;
                end else if (byte_i[7:3] == 5'b11110) begin
                  accum_d = CP_W'(byte_i[2:0]);
                  left_d  = 2'd3;
                  mode_d  = MODE_UTF8;
                  wait_d  = '0;
                end
              end
            endcase
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      wait_q  <= '0;
      accum_q <= '0;
      left_q  <= '0;
      plen_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      wait_q  <= wait_d;
      accum_q <= accum_d;
      left_q  <= left_d;
      plen_q  <= plen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_q[plen_q[HEAD_IDX_W-1:0]] <= byte_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_left_only_utf8: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q != 2'd0 |-> mode_q == MODE_UTF8)
    else $error("utf-8 byte count set outside a utf-8 sequence");

  a_plen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q <= PLEN_W'(MAX_PARAM_BYTES))
    else $error("parameter length beyond limit");

  a_no_step_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(mode_q) && $stable(wait_q) && $stable(plen_q))
    else $error("parser state moved without a step");
`endif

endmodule

// ===== hw/rtl/terminal_key_sequence_decoder.sv =====
// terminal_key_sequence_decoder: top level with input register, config registers and result register
// depends on tkd_pkg, tkd_in_if, tkd_out_if and tkd_decode
//
// usage
//   key_in carries one beat per received byte (command 0) or timer tick (command 1).
//   key_out carries zero or one key event per input beat: key_kind and code_point.
//   cfg_we_i writes esc_wait_ticks (index 0) or seq_wait_ticks (index 1) from
//   cfg_data_i; write only while no beat is in flight.
//   an accepted beat sits in the input register and is decoded from there into
//   the result register once that register is free or key_out.ready is high.
//   throughput is one beat per cycle unless key_out stalls: the decode of a
//   beat is one pass of short logic between the input and result registers.
//   when key_out is stalled the result register holds, one more beat is taken
//   into the input register, and key_in.ready then drops until key_out moves.
//   reset clears both registers' valid flags and puts the parser back to idle,
//   the wait registers return to 30 and 50 ticks.

module terminal_key_sequence_decoder import tkd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tkd_in_if.sink               key_in,
  tkd_out_if.source            key_out,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic             in_vld_q, in_vld_d;
  logic             in_cmd_q;
  logic [7:0]       in_byte_q;
  logic             out_vld_q, out_vld_d;
  key_kind_e        out_kind_q;
  logic [CP_W-1:0]  out_cp_q;
  logic [CFG_W-1:0] esc_wait_q;
  logic [CFG_W-1:0] seq_wait_q;
  logic             step;
  logic             in_beat;
  key_res_t         res;

  assign step         = in_vld_q && (!out_vld_q || key_out.ready);
  assign key_in.ready = !in_vld_q || step;
  assign in_beat      = key_in.valid && key_in.ready;

  assign key_out.valid      = out_vld_q;
  assign key_out.key_kind   = out_kind_q;
  assign key_out.code_point = out_cp_q;

  tkd_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .cmd_i      (in_cmd_q),
    .byte_i     (in_byte_q),
    .esc_wait_i (esc_wait_q),
    .seq_wait_i (seq_wait_q),
    .res_o      (res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_beat) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = res.vld;
    end else if (key_out.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      esc_wait_q <= ESC_WAIT_RST;
      seq_wait_q <= SEQ_WAIT_RST;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ESC_WAIT: esc_wait_q <= cfg_data_i;
          CFG_SEQ_WAIT: seq_wait_q <= cfg_data_i;
          default:      esc_wait_q <= esc_wait_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      in_cmd_q  <= key_in.command;
      in_byte_q <= key_in.data_byte;
    end
    if (step && res.vld) begin
      out_kind_q <= res.kind;
      out_cp_q   <= res.cp;
    end
  end

`ifndef NO_ASSERTIONS
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !step |=> in_vld_q && $stable(in_cmd_q) && $stable(in_byte_q))
    else $error("pending input beat lost or changed");

  a_cp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_kind_q != KEY_CHAR && out_kind_q != KEY_PASTE_BYTE |-> out_cp_q == '0)
    else $error("code point set for a key without one");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_kind_q <= KEY_PASTE_END)
    else $error("key kind out of range");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for terminal_key_sequence_decoder, directed table then random
// key streams checked key by key against an in-bench decoder; needs tkd_pkg, tkd_in_if,
// tkd_out_if and the decoder rtl

module tb_top;
  import tkd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BEATS  = 225;
  localparam int LONG_HOLD    = 64;

  typedef enum logic [1:0] {
    EXP_MODEL,
    EXP_KEY,
    EXP_NONE
  } row_exp_e;

  typedef struct {
    cmd_e            cmd;
    logic [7:0]      data;
    row_exp_e        how;
    key_kind_e       kind;
    logic [CP_W-1:0] cp;
  } stim_row_t;

  typedef struct {
    key_kind_e       kind;
    logic [CP_W-1:0] cp;
  } key_evt_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  tkd_in_if  key_in_if ();
  tkd_out_if key_out_if ();

  terminal_key_sequence_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_in     (key_in_if),
    .key_out    (key_out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // decoder state kept by the bench
  parse_mode_e       mode_q     = MODE_IDLE;
  logic [WAIT_W-1:0] wait_cnt_q = '0;
  logic [WAIT_W-1:0] esc_lim_q  = ESC_WAIT_RST;
  logic [WAIT_W-1:0] seq_lim_q  = SEQ_WAIT_RST;
  logic [CP_W-1:0]   accum_q    = '0;
  logic [1:0]        left_q     = '0;
  int                plen_q     = 0;
  logic [7:0]        head_q [HEAD_DEPTH] = '{default: 8'h00};
  logic [7:0]        win_q [6] = '{default: 8'h00};
  int                fill_q     = 0;

  key_evt_t keys_due [$];
  int       beats_in   = 0;
  int       mismatches = 0;
  bit       calm_in    = 1'b0;
  bit       calm_out   = 1'b0;

  logic [7:0] csi_finals [8] = '{"A", "B", "C", "D", "H", "F", "Z", "~"};
  logic [7:0] edit_bytes [5] = '{BYTE_DEL, BYTE_BS, BYTE_CR, BYTE_LF, BYTE_TAB};

  stim_row_t opening_rows [26] = '{
    '{CMD_BYTE, 8'h00,       EXP_NONE,  KEY_CHAR,      21'h0},
    '{CMD_BYTE, 8'h20,       EXP_KEY,   KEY_CHAR,      21'h20},
    '{CMD_BYTE, 8'h7e,       EXP_KEY,   KEY_CHAR,      21'h7e},
    '{CMD_BYTE, BYTE_DEL,    EXP_KEY,   KEY_BACKSPACE, 21'h0},
    '{CMD_BYTE, BYTE_CR,     EXP_KEY,   KEY_ENTER,     21'h0},
    '{CMD_BYTE, BYTE_CTRL_C, EXP_KEY,   KEY_CTRL_C,    21'h0},
    '{CMD_TICK, 8'ha5,       EXP_NONE,  KEY_CHAR,      21'h0},
    '{CMD_BYTE, 8'h80,       EXP_NONE,  KEY_CHAR,      21'h0},
    '{CMD_BYTE, 8'hff,       EXP_NONE,  KEY_CHAR,      21'h0},
    '{CMD_BYTE, 8'hc3,       EXP_NONE,  KEY_CHAR,      21'h0},
    '{CMD_BYTE, 8'ha9,       EXP_KEY,   KEY_CHAR,      21'he9},
    '{CMD_BYTE, 8'hf4,       EXP_MODEL, KEY_CHAR,      21'h0},
    '{CMD_BYTE, 8'h8f,       EXP_MODEL, KEY_CHAR,      21'h0},
    '{CMD_BYTE, 8'hbf,       EXP_MODEL, KEY_CHAR,      21'h0},
    '{CMD_BYTE, 8'hbf,       EXP_KEY,   KEY_CHAR,      21'h10ffff},
    '{CMD_BYTE, BYTE_ESC,    EXP_MODEL, KEY_CHAR,      21'h0},
    '{CMD_BYTE, BYTE_LBRACK, EXP_MODEL, KEY_CHAR,      21'h0},
    '{CMD_BYTE, BYTE_FOUR,   EXP_MODEL, KEY_CHAR,      21'h0},
    '{CMD_BYTE, BYTE_TILDE,  EXP_KEY,   KEY_END,       21'h0},
    '{CMD_BYTE, BYTE_ESC,    EXP_MODEL, KEY_CHAR,      21'h0},
    '{CMD_BYTE, BYTE_SS3,    EXP_MODEL, KEY_CHAR,      21'h0},
    '{CMD_BYTE, "A",         EXP_KEY,   KEY_UP,        21'h0},
    '{CMD_BYTE, BYTE_ESC,    EXP_MODEL, KEY_CHAR,      21'h0},
    '{CMD_BYTE, BYTE_LF,     EXP_KEY,   KEY_NEWLINE,   21'h0},
    '{CMD_BYTE, 8'he2,       EXP_MODEL, KEY_CHAR,      21'h0},
    '{CMD_BYTE, 8'h41,       EXP_NONE,  KEY_CHAR,      21'h0}
  };

  function automatic bit nav_key(input logic [7:0] b, output key_kind_e k);
    k = KEY_CHAR;
    case (b)
      "A": k = KEY_UP;
      "B": k = KEY_DOWN;
      "C": k = KEY_RIGHT;
      "D": k = KEY_LEFT;
      "H": k = KEY_HOME;
      "F": k = KEY_END;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // advances the bench copy of the parser by one beat, returns 1 when a key comes out
  function automatic bit decode_key(input cmd_e c, input logic [7:0] b,
                                    output key_kind_e k, output logic [CP_W-1:0] cp);
    logic [WAIT_W-1:0] lim;
    k  = KEY_CHAR;
    cp = '0;
    if (c == CMD_TICK) begin
      case (mode_q)
        MODE_ESC: lim = esc_lim_q;
        MODE_CSI, MODE_SS3, MODE_UTF8: lim = seq_lim_q;
        default: return 1'b0;
      endcase
      if (wait_cnt_q != WAIT_MAX) wait_cnt_q++;
      if (wait_cnt_q < lim) return 1'b0;
      wait_cnt_q = '0;
      if (mode_q == MODE_ESC) begin
        mode_q = MODE_IDLE;
        k = KEY_ESC;
        return 1'b1;
      end
      mode_q = MODE_IDLE;
      left_q = '0;
      return 1'b0;
    end
    case (mode_q)
      MODE_ESC: begin
        if (b == BYTE_LBRACK) begin
          mode_q = MODE_CSI;
          plen_q = 0;
          wait_cnt_q = '0;
          return 1'b0;
        end
        if (b == BYTE_SS3) begin
          mode_q = MODE_SS3;
          wait_cnt_q = '0;
          return 1'b0;
        end
        mode_q = MODE_IDLE;
        if (b == BYTE_CR || b == BYTE_LF) begin
          k = KEY_NEWLINE;
          return 1'b1;
        end
        return 1'b0;
      end
      MODE_CSI: begin
        wait_cnt_q = '0;
        if (b >= FINAL_LO && b <= FINAL_HI) begin
          mode_q = MODE_IDLE;
          if (nav_key(b, k)) return 1'b1;
          if (b == BYTE_Z) begin
            k = KEY_SHIFT_TAB;
            return 1'b1;
          end
          if (b != BYTE_TILDE) return 1'b0;
          if (plen_q == 3 && head_q[0] == BYTE_TWO && head_q[1] == BYTE_ZERO &&
              head_q[2] == BYTE_ZERO) begin
            mode_q = MODE_PASTE;
            fill_q = 0;
            return 1'b0;
          end
          if (plen_q == 1) begin
            if (head_q[0] == BYTE_ONE || head_q[0] == BYTE_SEVEN) begin
              k = KEY_HOME;
              return 1'b1;
            end
            if (head_q[0] == BYTE_FOUR || head_q[0] == BYTE_EIGHT) begin
              k = KEY_END;
              return 1'b1;
            end
          end
          return 1'b0;
        end
        if (plen_q < HEAD_DEPTH) head_q[plen_q] = b;
        plen_q++;
        if (plen_q > MAX_PARAM_BYTES) begin
          plen_q = 0;
          mode_q = MODE_IDLE;
        end
        return 1'b0;
      end
      MODE_SS3: begin
        mode_q = MODE_IDLE;
        return nav_key(b, k);
      end
      MODE_UTF8: begin
        wait_cnt_q = '0;
        if (b[7:6] != 2'b10) begin
          mode_q = MODE_IDLE;
          left_q = '0;
          return 1'b0;
        end
        accum_q = {accum_q[CP_W-7:0], b[5:0]};
        if (left_q != 0) left_q--;
        if (left_q != 0) return 1'b0;
        mode_q = MODE_IDLE;
        cp = accum_q;
        return 1'b1;
      end
      MODE_PASTE: begin
        if (fill_q < WIN_DEPTH) begin
          win_q[fill_q] = b;
          fill_q++;
          return 1'b0;
        end
        win_q[5] = b;
        if ({win_q[0], win_q[1], win_q[2], win_q[3], win_q[4], win_q[5]} == PASTE_TERM) begin
          fill_q = 0;
          mode_q = MODE_IDLE;
          k = KEY_PASTE_END;
          return 1'b1;
        end
        k  = KEY_PASTE_BYTE;
        cp = CP_W'(win_q[0]);
        for (int i = 0; i < 5; i++) win_q[i] = win_q[i+1];
        return 1'b1;
      end
      default: begin
        mode_q = MODE_IDLE;
        case (b)
          BYTE_ESC: begin
            mode_q = MODE_ESC;
            wait_cnt_q = '0;
            return 1'b0;
          end
          BYTE_CR, BYTE_LF: begin
            k = KEY_ENTER;
            return 1'b1;
          end
          BYTE_DEL, BYTE_BS: begin
            k = KEY_BACKSPACE;
            return 1'b1;
          end
          BYTE_TAB: begin
            k = KEY_TAB;
            return 1'b1;
          end
          BYTE_CTRL_C: begin
            k = KEY_CTRL_C;
            return 1'b1;
          end
          BYTE_CTRL_D: begin
            k = KEY_CTRL_D;
            return 1'b1;
          end
          BYTE_CTRL_O: begin
            k = KEY_CTRL_O;
            return 1'b1;
          end
          BYTE_CTRL_E: begin
            k = KEY_CTRL_E;
            return 1'b1;
          end
          default: ;
        endcase
        if (b < 8'h20) return 1'b0;
        if (b < 8'h80) begin
          cp = CP_W'(b);
          return 1'b1;
        end
        if (b[7:5] == 3'b110) begin
          accum_q = CP_W'(b[4:0]);
          left_q  = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          accum_q = CP_W'(b[3:0]);
          left_q  = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          accum_q = CP_W'(b[2:0]);
          left_q  = 2'd3;
        end else begin
          return 1'b0;
        end
        mode_q = MODE_UTF8;
        wait_cnt_q = '0;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic put_beat(input cmd_e c, input logic [7:0] b, input row_exp_e how,
                          input key_kind_e tk, input logic [CP_W-1:0] tcp);
    int              gap;
    bit              hit;
    key_kind_e       k;
    logic [CP_W-1:0] cp;
    gap = calm_in ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      key_in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    key_in_if.valid     <= 1'b1;
    key_in_if.command   <= c;
    key_in_if.data_byte <= b;
    do @(posedge clk_i); while (!key_in_if.ready);
    hit = decode_key(c, b, k, cp);
    case (how)
      EXP_MODEL: if (hit) keys_due.insert(keys_due.size(), '{k, cp});
      EXP_KEY:   keys_due.insert(keys_due.size(), '{tk, tcp});
      default: ;
    endcase
    beats_in++;
    if (beats_in % 64 == 0) calm_in = ($urandom_range(0, 3) == 0);
  endtask

  task automatic put_byte(input logic [7:0] b);
    put_beat(CMD_BYTE, b, EXP_MODEL, KEY_CHAR, '0);
  endtask

  task automatic put_ticks(input int n);
    repeat (n) put_beat(CMD_TICK, 8'($urandom()), EXP_MODEL, KEY_CHAR, '0);
  endtask

  // ticks between bytes of a sequence, now and then exactly enough to time it out
  task automatic gap_ticks(input logic [WAIT_W-1:0] lim);
    int n;
    n = 0;
    if ($urandom_range(0, 5) == 0) begin
      if (lim <= 40 && $urandom_range(0, 3) == 0) n = int'(lim);
      else if (lim > 1) n = $urandom_range(1, (lim > 6) ? 6 : lim - 1);
    end
    put_ticks(n);
  endtask

  task automatic put_sequence();
    int         pick;
    int         n;
    int         m;
    logic [7:0] b;
    pick = $urandom_range(0, 15);
    case (pick)
      0, 1, 2: put_byte(8'($urandom_range(8'h20, 8'h7e)));
      3: put_byte(8'($urandom_range(8'h00, 8'h1f)));
      4: put_byte(edit_bytes[$urandom_range(0, 4)]);
      5: begin
        put_byte(BYTE_ESC);
        gap_ticks(esc_lim_q);
        if ($urandom_range(0, 1)) put_byte($urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
        else put_byte(8'($urandom()));
      end
      6: begin
        put_byte(BYTE_ESC);
        if (esc_lim_q <= 40) begin
          put_ticks(int'(esc_lim_q));
        end else begin
          put_ticks($urandom_range(1, 6));
          put_byte(BYTE_CR);
        end
      end
      7, 8: begin
        put_byte(BYTE_ESC);
        gap_ticks(esc_lim_q);
        put_byte(BYTE_LBRACK);
        n = $urandom_range(0, 7);
        // runs either side of the parameter limit
        if (n == 7) n = $urandom_range(MAX_PARAM_BYTES - 2, MAX_PARAM_BYTES + 2);
        for (int i = 0; i < n; i++) begin
          gap_ticks(seq_lim_q);
          if ($urandom_range(0, 7) == 0)
            b = $urandom_range(0, 1) ? 8'($urandom_range(8'h00, 8'h3f)) :
                                       8'($urandom_range(8'h7f, 8'hff));
          else
            b = 8'($urandom_range(8'h30, 8'h3f));
          put_byte(b);
        end
        gap_ticks(seq_lim_q);
        m = $urandom_range(0, 9);
        put_byte(m < 8 ? csi_finals[m] : 8'($urandom_range(FINAL_LO, FINAL_HI)));
      end
      9: begin
        put_byte(BYTE_ESC);
        gap_ticks(esc_lim_q);
        put_byte(BYTE_SS3);
        gap_ticks(seq_lim_q);
        m = $urandom_range(0, 7);
        put_byte(m < 6 ? csi_finals[m] : 8'($urandom()));
      end
      10, 11: begin
        n = $urandom_range(1, 3);
        b = 8'($urandom());
        case (n)
          1: put_byte({3'b110, b[4:0]});
          2: put_byte({4'b1110, b[3:0]});
          default: put_byte({5'b11110, b[2:0]});
        endcase
        for (int i = 0; i < n; i++) begin
          gap_ticks(seq_lim_q);
          b = 8'($urandom());
          if ($urandom_range(0, 11) == 0) put_byte(b);
          else put_byte({2'b10, b[5:0]});
        end
      end
      12: put_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hbf)) :
                                          8'($urandom_range(8'hf8, 8'hff)));
      13: begin
        put_byte(BYTE_ESC);
        put_byte(BYTE_LBRACK);
        put_byte(BYTE_TWO);
        put_byte(BYTE_ZERO);
        put_byte(BYTE_ZERO);
        put_byte(BYTE_TILDE);
        n = $urandom_range(0, 24);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 9))
            0: put_byte(BYTE_ESC);
            1: begin
              // partial terminator
              m = $urandom_range(1, 5);
              for (int j = 0; j < m; j++) put_byte(PASTE_TERM[47-8*j -: 8]);
            end
            2: put_ticks(1);
            3: put_byte(8'($urandom()));
            default: put_byte(8'($urandom_range(8'h20, 8'h7e)));
          endcase
        end
        for (int j = 0; j < 6; j++) put_byte(PASTE_TERM[47-8*j -: 8]);
      end
      14: begin
        if ($urandom_range(0, 1)) put_ticks(1);
        else put_byte(8'($urandom()));
      end
      default: begin
        put_byte(BYTE_ESC);
        put_byte(BYTE_LBRACK);
        put_byte(8'($urandom_range(8'h30, 8'h39)));
        if ($urandom_range(0, 3) == 0) put_byte(8'($urandom_range(8'h30, 8'h39)));
        put_byte(BYTE_TILDE);
      end
    endcase
  endtask

  task automatic settle();
    key_in_if.valid <= 1'b0;
    while (keys_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_waits(input logic [WAIT_W-1:0] esc_ticks, input logic [WAIT_W-1:0] seq_ticks);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ESC_WAIT;
    cfg_data_i <= esc_ticks;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SEQ_WAIT;
    cfg_data_i <= seq_ticks;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    esc_lim_q = esc_ticks;
    seq_lim_q = seq_ticks;
  endtask

  initial begin : stimulus
    int goal;
    key_in_if.valid     = 1'b0;
    key_in_if.command   = CMD_BYTE;
    key_in_if.data_byte = 8'h00;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_ESC_WAIT;
    cfg_data_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (opening_rows[i])
      put_beat(opening_rows[i].cmd, opening_rows[i].data, opening_rows[i].how,
               opening_rows[i].kind, opening_rows[i].cp);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        settle();
        case (ph)
          1: set_waits(16'd1, 16'd1);
          2: set_waits(16'hffff, 16'hffff);
          3: set_waits(16'd3, 16'd5);
          default: set_waits(16'($urandom_range(2, 12)), 16'($urandom_range(1, 8)));
        endcase
      end
      goal = beats_in + PHASE_BEATS;
      while (beats_in < goal) put_sequence();
    end
    settle();
    if (mismatches == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  initial begin : key_sink
    int       stall;
    int       n_keys;
    key_evt_t want;
    key_out_if.ready = 1'b0;
    n_keys = 0;
    wait (rst_ni == 1'b1);
    forever begin
      // long hold-offs let the input side back up
      if (n_keys == 150 || n_keys == 700) stall = LONG_HOLD;
      else stall = calm_out ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        key_out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      key_out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!key_out_if.valid);
      n_keys++;
      if (keys_due.size() == 0) begin
        $display("%0t: unexpected key, expected none, got kind %0d cp %h",
                 $time, key_out_if.key_kind, key_out_if.code_point);
        mismatches++;
      end else begin
        want = keys_due[0];
        keys_due.delete(0);
        if (key_out_if.key_kind != want.kind) begin
          $display("%0t: key_kind expected %0d got %0d", $time, want.kind, key_out_if.key_kind);
          mismatches++;
        end
        if (key_out_if.code_point != want.cp) begin
          $display("%0t: code_point expected %h got %h", $time, want.cp, key_out_if.code_point);
          mismatches++;
        end
      end
      if (n_keys % 40 == 0) calm_out = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
